FILE: design/assert_macros.svh
// Shared assertion macros; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/ifsr_pkg.sv
`timescale 1ns / 1ps

package ifsr_pkg;

  localparam int unsigned INPUT_BITS_DEF = 31;
  localparam int unsigned ROOT_BITS      = 16;

  typedef struct packed {
    logic valid;
  } ifsr_ctl_t;

endpackage

FILE: design/ifsr_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ifsr_cell #(
  parameter int unsigned W    = 32,
  parameter int unsigned STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ifsr_pkg::ifsr_ctl_t ctl_i,
  input  logic [W-1:0]       rest_i,
  input  logic [W-1:0]       acc_i,
  output ifsr_pkg::ifsr_ctl_t ctl_o,
  output logic [W-1:0]       rest_o,
  output logic [W-1:0]       acc_o
);

  localparam logic [W-1:0] PROBE = W'(1) << (2 * STEP);

  ifsr_pkg::ifsr_ctl_t ctl_r;
  logic [W-1:0]        rest_r;
  logic [W-1:0]        acc_r;
  logic [W-1:0]        trial;
  logic                take;
  logic [W-1:0]        rest_nxt;
  logic [W-1:0]        acc_nxt;

  always_comb begin
    trial = acc_i + PROBE;
    take  = (rest_i >= trial);
    if (take) begin
      rest_nxt = rest_i - trial;
      acc_nxt  = (acc_i >> 1) + PROBE;
    end else begin
      rest_nxt = rest_i;
      acc_nxt  = acc_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    acc_r  <= acc_nxt;
  end

  assign ctl_o  = ctl_r;
  assign rest_o = rest_r;
  assign acc_o  = acc_r;

  `ASSERT_NXT(a_rest_no_grow, ctl_i.valid, rest_r <= $past(rest_i))
  `ASSERT_NXT(a_valid_moves, ctl_i.valid, ctl_r.valid)
  `ASSERT_NXT(a_take_sets_bit, ctl_i.valid && take, acc_r >= PROBE)

endmodule

FILE: design/integer_floor_square_root.sv
// Integer floor square root, one root bit resolved per cell.
// Each cell registers its step, so a radicand passes through every cell of the chain from start to out_valid.
// Throughput: one transaction per cycle; busy stays low, the cell chain is fully pipelined.
// The receiver cannot stall: out_valid is a one-cycle strobe with out_root.
// Reset (rst_n low, synchronous) drops every transaction in flight; no result follows it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_floor_square_root #(
  parameter int unsigned INPUT_BITS = ifsr_pkg::INPUT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [INPUT_BITS-1:0]          in_radicand,
  output logic                           out_valid,
  output logic [ifsr_pkg::ROOT_BITS-1:0] out_root
);

  localparam int unsigned RB = (INPUT_BITS + 1) / 2;
  localparam int unsigned W  = INPUT_BITS + 1;

  ifsr_pkg::ifsr_ctl_t ctl_w  [RB+1];
  logic [W-1:0]        rest_w [RB+1];
  logic [W-1:0]        acc_w  [RB+1];

  assign busy             = 1'b0;
  assign ctl_w[0].valid   = start && !busy;
  assign rest_w[0]        = W'(in_radicand);
  assign acc_w[0]         = '0;

  for (genvar g = 0; g < RB; g++) begin : g_cell
    ifsr_cell #(
      .W    (W),
      .STEP (RB - 1 - g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_w[g]),
      .rest_i (rest_w[g]),
      .acc_i  (acc_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .rest_o (rest_w[g+1]),
      .acc_o  (acc_w[g+1])
    );
  end

  assign out_valid = ctl_w[RB].valid;
  assign out_root  = ifsr_pkg::ROOT_BITS'(acc_w[RB]);

  `ASSERT_IMP(a_out_follows_start, out_valid, $past(start, RB))
  `ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `ASSERT_IMP(a_rest_below_bound, out_valid, rest_w[RB] <= (acc_w[RB] << 1))

endmodule

FILE: bench/tb_integer_floor_square_root.sv
`timescale 1ns / 1ps

module tb_integer_floor_square_root;

  localparam int unsigned RADICAND_BITS = ifsr_pkg::INPUT_BITS_DEF;
  localparam int unsigned PIPE_DEPTH    = (RADICAND_BITS + 1) / 2;
  localparam int unsigned RANDOM_ITEMS  = 850;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [RADICAND_BITS-1:0]         in_radicand;
  logic                             out_valid;
  logic [ifsr_pkg::ROOT_BITS-1:0]   out_root;

  logic [ifsr_pkg::ROOT_BITS-1:0]   pending_roots[$];
  bit                               failed;
  int unsigned                      burst_left;

  integer_floor_square_root #(
    .INPUT_BITS(RADICAND_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_radicand(in_radicand),
    .out_valid  (out_valid),
    .out_root   (out_root)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // restoring digit-by-digit root, one root bit per pass
  function automatic logic [ifsr_pkg::ROOT_BITS-1:0] floor_root_of(
    input logic [RADICAND_BITS-1:0] radicand
  );
    logic [63:0] remain;
    logic [63:0] partial;
    logic [63:0] bit_weight;
    logic [63:0] trial;
    remain     = 64'(radicand);
    partial    = '0;
    bit_weight = 64'd1 << 62;
    while (bit_weight > remain) bit_weight = bit_weight >> 2;
    while (bit_weight != 0) begin
      trial = partial + bit_weight;
      if (remain >= trial) begin
        remain  = remain - trial;
        partial = (partial >> 1) + bit_weight;
      end else begin
        partial = partial >> 1;
      end
      bit_weight = bit_weight >> 2;
    end
    return partial[ifsr_pkg::ROOT_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected root transaction: expected none, actual %0d", $time,
                 out_root);
        failed = 1'b1;
      end else begin
        logic [ifsr_pkg::ROOT_BITS-1:0] want;
        want = pending_roots.pop_front();
        if (out_root !== want) begin
          $display("%0t: root mismatch: expected %0d, actual %0d", $time, want, out_root);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_radicand(input logic [RADICAND_BITS-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    start       <= 1'b1;
    in_radicand <= value;
    do @(posedge clk); while (busy);
    pending_roots.push_back(floor_root_of(value));
  endtask

  task automatic drain_roots();
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    logic [RADICAND_BITS-1:0] max_value;
    max_value = '1;
    send_radicand('0);
    send_radicand(RADICAND_BITS'(1));
    send_radicand(RADICAND_BITS'(2));
    send_radicand(RADICAND_BITS'(3));
    send_radicand(RADICAND_BITS'(4));
    send_radicand(max_value);
    send_radicand(max_value - RADICAND_BITS'(1));
    send_radicand(RADICAND_BITS'(46340 * 46340));
    send_radicand(RADICAND_BITS'(46340 * 46340 - 1));
    send_radicand(RADICAND_BITS'(1) << (RADICAND_BITS - 1));
    send_radicand(RADICAND_BITS'(31'h5555_5555));
    send_radicand(RADICAND_BITS'(31'h2AAA_AAAA));
    send_radicand('0);
    drain_roots();
  endtask

  task automatic test_perfect_squares();
    int unsigned k;
    for (int i = 0; i < 10; i++) begin
      k = (i < 5) ? i + 5 : $urandom_range(100, 46340);
      send_radicand(RADICAND_BITS'(k * k));
      send_radicand(RADICAND_BITS'(k * k - 1));
    end
    drain_roots();
  endtask

  task automatic test_random_uniform(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_radicand(RADICAND_BITS'($urandom));
    drain_roots();
  endtask

  task automatic test_random_scaled(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_radicand(RADICAND_BITS'($urandom >> $urandom_range(1, 31)));
    drain_roots();
  endtask

  task automatic test_near_squares(input int unsigned count);
    longint unsigned k;
    longint signed   value;
    for (int unsigned i = 0; i < count; i++) begin
      k     = 64'($urandom_range(0, 46340));
      value = longint'(k * k) + longint'($urandom_range(0, 2)) - 64'sd1;
      if (value < 0) value = 0;
      send_radicand(RADICAND_BITS'(value));
    end
    drain_roots();
  endtask

  initial begin
    burst_left  = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_radicand <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_perfect_squares();
    test_random_uniform(RANDOM_ITEMS * 2 / 5);
    test_random_scaled(RANDOM_ITEMS * 3 / 10);
    test_near_squares(RANDOM_ITEMS * 3 / 10);

    drain_roots();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (pending_roots.size() != 0) begin
      $display("%0t: roots still outstanding: expected 0, actual %0d", $time,
               pending_roots.size());
    end
    if (!failed && pending_roots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/ifsr_pkg.sv
design/ifsr_cell.sv
design/integer_floor_square_root.sv
bench/tb_integer_floor_square_root.sv
